/* rtl/ofe_pkg.sv */
package ofe_pkg;

  localparam int CH_W       = 2;
  localparam int CHANNELS   = 2 ** CH_W;
  localparam int MAX_FRAME  = 64;
  localparam int LEN_W      = 7;
  localparam int POS_W      = 7;
  localparam int RING_SLOTS = 2 ** POS_W;
  localparam int RAM_DEPTH  = CHANNELS * RING_SLOTS;
  localparam int RAM_AW     = CH_W + POS_W;
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 6;
  localparam int JOBQ_DEPTH = CHANNELS;
  localparam int JOBQ_AW    = CH_W;
  localparam int OUT_AW     = 2;
  localparam int OUT_DEPTH  = 2 ** OUT_AW;
  localparam int OUT_CW     = OUT_AW + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_HOP_LENGTH   = 2'd1,
    REG_ZERO_PREFILL = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    logic [LEN_W-1:0] frame;
    logic [LEN_W-1:0] hop;
    logic [LEN_W-1:0] cap;
    logic [IDX_W-1:0] prefill;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] rp;
    logic [IDX_W-1:0] ov;
    logic             ok;
  } job_t;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
  } done_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    pos;
    logic                ok;
    logic                last;
  } res_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    return (v == '0) ? LEN_W'(1) :
           (v > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : v;
  endfunction

endpackage

/* rtl/ofe_ram.sv */
module ofe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ofe_jobq.sv */
module ofe_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ofe_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ofe_pkg::job_t data_o
);
  import ofe_pkg::*;

  job_t               entry_q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [JOBQ_AW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + JOBQ_AW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + JOBQ_AW'(1) : rd_q;
    cnt_d = cnt_q + (JOBQ_AW+1)'(do_push) - (JOBQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_jobq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (JOBQ_AW+1)'(JOBQ_DEPTH))
    else $error("job queue count beyond depth");
`endif

endmodule

/* rtl/ofe_front.sv */
module ofe_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [ofe_pkg::CH_W-1:0]             ch_i,
  input  logic signed [ofe_pkg::SAMPLE_W-1:0]  sample_i,
  input  ofe_pkg::cfg_t                        cfg_i,
  input  logic                                 setup_i,
  input  logic                                 jobq_full_i,
  output logic                                 job_push_o,
  output ofe_pkg::job_t                        job_o,
  input  ofe_pkg::done_t                       done_i,
  output logic                                 ram_we_o,
  output logic [ofe_pkg::RAM_AW-1:0]           ram_waddr_o,
  output logic [ofe_pkg::SAMPLE_W-1:0]         ram_wdata_o
);
  import ofe_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [CH_W-1:0]     in_ch_q;
  logic [SAMPLE_W-1:0] in_sample_q;

  logic [POS_W-1:0]    rp_q   [CHANNELS];
  logic [POS_W-1:0]    rp_d   [CHANNELS];
  logic [LEN_W-1:0]    fill_q [CHANNELS];
  logic [LEN_W-1:0]    fill_d [CHANNELS];
  logic [IDX_W-1:0]    hop_q  [CHANNELS];
  logic [IDX_W-1:0]    hop_d  [CHANNELS];
  logic [IDX_W-1:0]    ov_q   [CHANNELS];
  logic [IDX_W-1:0]    ov_d   [CHANNELS];
  logic [CHANNELS-1:0] pending_q, pending_d;

  logic             fire, accept, hop_done, frame_ok;
  logic [POS_W-1:0] rp0, rp1, rp3, wpos;
  logic [LEN_W-1:0] fill0, fill1, fill2;
  logic [POS_W:0]   wsum, rsum;
  logic [LEN_W-1:0] hop2;
  logic [IDX_W-1:0] ov_next;

  assign fire   = in_valid_q & ~setup_i & ~pending_q[in_ch_q] & ~jobq_full_i;
  assign full_o = setup_i | (in_valid_q & ~fire);
  assign accept = push_i & ~full_o;

  // ring bookkeeping for the held sample
  always_comb begin
    rp0   = rp_q[in_ch_q];
    fill0 = fill_q[in_ch_q];
    if (fill0 >= cfg_i.cap) begin
      rp1   = (rp0 + POS_W'(1) == cfg_i.cap) ? '0 : rp0 + POS_W'(1);
      fill1 = cfg_i.cap - LEN_W'(1);
    end else begin
      rp1   = rp0;
      fill1 = fill0;
    end
    wsum     = {1'b0, rp1} + {1'b0, fill1};
    wpos     = (wsum >= {1'b0, cfg_i.cap}) ? POS_W'(wsum - {1'b0, cfg_i.cap}) :
               POS_W'(wsum);
    fill2    = fill1 + LEN_W'(1);
    hop2     = {1'b0, hop_q[in_ch_q]} + LEN_W'(1);
    hop_done = (hop2 >= cfg_i.hop);
    frame_ok = (fill2 >= cfg_i.frame);
    rsum     = {1'b0, rp1} + {1'b0, cfg_i.hop};
    rp3      = (rsum >= {1'b0, cfg_i.cap}) ? POS_W'(rsum - {1'b0, cfg_i.cap}) :
               POS_W'(rsum);
    ov_next  = ov_q[in_ch_q];
    if ((ov_q[in_ch_q] < cfg_i.prefill) && ({1'b0, ov_q[in_ch_q]} == wpos)) begin
      ov_next = ov_q[in_ch_q] + IDX_W'(1);
    end
  end

  always_comb begin
    rp_d      = rp_q;
    fill_d    = fill_q;
    hop_d     = hop_q;
    ov_d      = ov_q;
    pending_d = pending_q;
    if (done_i.valid) begin
      pending_d[done_i.ch] = 1'b0;
    end
    if (setup_i) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rp_d[c]   = '0;
        fill_d[c] = LEN_W'(cfg_i.prefill);
        hop_d[c]  = '0;
        ov_d[c]   = '0;
      end
    end else if (fire) begin
      ov_d[in_ch_q] = ov_next;
      if (hop_done) begin
        hop_d[in_ch_q]     = '0;
        pending_d[in_ch_q] = 1'b1;
        rp_d[in_ch_q]      = frame_ok ? rp3 : rp1;
        fill_d[in_ch_q]    = frame_ok ? fill2 - cfg_i.hop : fill2;
      end else begin
        hop_d[in_ch_q]  = IDX_W'(hop2);
        rp_d[in_ch_q]   = rp1;
        fill_d[in_ch_q] = fill2;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  assign job_push_o  = fire & hop_done;
  assign job_o.ch    = in_ch_q;
  assign job_o.rp    = rp1;
  assign job_o.ov    = ov_next;
  assign job_o.ok    = frame_ok;
  assign ram_we_o    = fire;
  assign ram_waddr_o = {in_ch_q, wpos};
  assign ram_wdata_o = in_sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pending_q  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        rp_q[c]   <= '0;
        fill_q[c] <= '0;
        hop_q[c]  <= '0;
        ov_q[c]   <= '0;
      end
    end else begin
      in_valid_q <= in_valid_d;
      pending_q  <= pending_d;
      rp_q       <= rp_d;
      fill_q     <= fill_d;
      hop_q      <= hop_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_ch_q     <= ch_i;
      in_sample_q <= sample_i;
    end
  end

`ifndef SYNTHESIS
  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i.valid |-> pending_q[done_i.ch])
    else $error("frame completion for a channel with no request outstanding");

  a_write_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (ram_waddr_o[POS_W-1:0] < cfg_i.cap))
    else $error("ring write beyond capacity");
`endif

endmodule

/* rtl/ofe_back.sv */
module ofe_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ofe_pkg::cfg_t                cfg_i,
  input  logic                         jobq_empty_i,
  output logic                         job_pop_o,
  input  ofe_pkg::job_t                job_i,
  output ofe_pkg::done_t               done_o,
  output logic                         ram_re_o,
  output logic [ofe_pkg::RAM_AW-1:0]   ram_raddr_o,
  input  logic [ofe_pkg::SAMPLE_W-1:0] ram_rdata_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output ofe_pkg::res_t                res_o
);
  import ofe_pkg::*;

  back_state_e      state_q, state_d;
  logic [CH_W-1:0]  ch_q;
  logic [POS_W-1:0] pos_q, pos_next;
  logic [IDX_W-1:0] ov_q;
  logic             ok_q;
  logic [IDX_W-1:0] k_q;

  logic             s1_valid_q;
  res_t             s1_res_q;
  logic             s1_zero_q;

  res_t             fifo_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_q, rd_q;
  logic [OUT_CW-1:0] cnt_q;

  logic             issue_ok, issue, is_last, is_zero, do_pop;
  res_t             push_res;

  assign issue_ok = (cnt_q + OUT_CW'(s1_valid_q)) < OUT_CW'(OUT_DEPTH);
  assign is_last  = ~ok_q | (({1'b0, k_q} + LEN_W'(1)) == cfg_i.frame);
  assign is_zero  = ~ok_q | ((pos_q >= {1'b0, ov_q}) && (pos_q < {1'b0, cfg_i.prefill}));
  assign pos_next = (pos_q + POS_W'(1) == cfg_i.cap) ? '0 : pos_q + POS_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!jobq_empty_i) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue_ok && is_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o    = 1'b0;
    issue        = 1'b0;
    case (state_q)
      BK_IDLE: job_pop_o = ~jobq_empty_i;
      BK_RUN:  issue     = issue_ok;
      default: ;
    endcase
    done_o.valid = issue & is_last;
    done_o.ch    = ch_q;
    ram_re_o     = issue & ok_q;
    ram_raddr_o  = {ch_q, pos_q};
  end

  always_comb begin
    push_res        = s1_res_q;
    push_res.sample = s1_zero_q ? '0 : ram_rdata_i;
  end

  assign do_pop  = pop_i & ~empty_o;
  assign empty_o = (cnt_q == '0);
  assign res_o   = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      s1_valid_q <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= issue;
      if (s1_valid_q) begin
        wr_q <= wr_q + OUT_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + OUT_AW'(1);
      end
      cnt_q <= cnt_q + OUT_CW'(s1_valid_q) - OUT_CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ch_q  <= job_i.ch;
      pos_q <= job_i.rp;
      ov_q  <= job_i.ov;
      ok_q  <= job_i.ok;
      k_q   <= '0;
    end else if (issue) begin
      pos_q <= pos_next;
      k_q   <= k_q + IDX_W'(1);
    end
    if (issue) begin
      s1_res_q.ch     <= ch_q;
      s1_res_q.sample <= '0;
      s1_res_q.pos    <= ok_q ? k_q : '0;
      s1_res_q.ok     <= ok_q;
      s1_res_q.last   <= is_last;
      s1_zero_q       <= is_zero;
    end
    if (s1_valid_q) begin
      fifo_q[wr_q] <= push_res;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (cnt_q < OUT_CW'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN && ok_q) |-> ({1'b0, k_q} < cfg_i.frame))
    else $error("frame index past frame length");
`endif

endmodule

/* rtl/overlapping_frame_extractor_core.sv */
// overlapping frame extractor
// input queue side: push with channel_index_i and sample_value_i, taken when full
// is low. each taken sample waits in the input register, then goes into its ring.
// result queue side: while empty is low the oldest result is on the out ports and
// pop takes it. a sample that completes a hop yields frame_length frame samples,
// or one result with frame_ok low when the ring holds too little.
// results of a run pass the ring memory read, the s1 result register and the result
// queue; a run streams one result per cycle from the ring memory's single read
// port while the result queue has room, and each job is first taken from the
// job queue in an idle state.
// samples of other channels keep flowing in while a frame is read out; a sample of
// a channel whose frame is still being read waits in the input register.
// config port: cfg_ready_o is always high; a write to a known register empties all
// rings. after reset and after such a write a setup pass works out the ring
// capacity and clears the channel state; full stays high meanwhile. ring memory
// contents need no clearing.
// when pop stays low the 4-entry result queue fills, the read side stops, and
// the input side stops once the job queue or the input register is blocked.
module overlapping_frame_extractor_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [ofe_pkg::CH_W-1:0]               channel_index_i,
  input  logic signed [ofe_pkg::SAMPLE_W-1:0]    sample_value_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [ofe_pkg::CH_W-1:0]               out_channel_o,
  output logic signed [ofe_pkg::SAMPLE_W-1:0]    out_sample_o,
  output logic [ofe_pkg::IDX_W-1:0]              position_in_frame_o,
  output logic                                   frame_ok_o,
  output logic                                   last_of_frame_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ofe_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [ofe_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import ofe_pkg::*;

  logic [LEN_W-1:0] frame_len_q, frame_len_d;
  logic [LEN_W-1:0] hop_len_q, hop_len_d;
  logic             prefill_q, prefill_d;
  logic [LEN_W-1:0] cap_q, cap_d;
  logic [LEN_W-1:0] frame_eff, hop_eff;
  logic             setup_busy, cfg_we;
  cfg_t             cfg;

  logic             jobq_full, jobq_empty, job_push, job_pop;
  job_t             job_in, job_out;
  done_t            done;
  logic             ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  res_t             res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign frame_eff   = clamp_len(frame_len_q);
  assign hop_eff     = clamp_len(hop_len_q);
  assign setup_busy  = (cap_q < frame_eff);

  // capacity: smallest multiple of the hop that holds a frame
  always_comb begin
    frame_len_d = frame_len_q;
    hop_len_d   = hop_len_q;
    prefill_d   = prefill_q;
    cap_d       = setup_busy ? cap_q + hop_eff : cap_q;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_LENGTH: begin
          frame_len_d = LEN_W'(cfg_data_i);
          cap_d       = '0;
        end
        REG_HOP_LENGTH: begin
          hop_len_d = LEN_W'(cfg_data_i);
          cap_d     = '0;
        end
        REG_ZERO_PREFILL: begin
          prefill_d = cfg_data_i[0];
          cap_d     = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.frame   = frame_eff;
    cfg.hop     = hop_eff;
    cfg.cap     = cap_q;
    cfg.prefill = (prefill_q && (frame_eff > hop_eff)) ? IDX_W'(frame_eff - hop_eff) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= LEN_W'(32);
      hop_len_q   <= LEN_W'(16);
      prefill_q   <= 1'b0;
      cap_q       <= '0;
    end else begin
      frame_len_q <= frame_len_d;
      hop_len_q   <= hop_len_d;
      prefill_q   <= prefill_d;
      cap_q       <= cap_d;
    end
  end

  ofe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .ch_i        (channel_index_i),
    .sample_i    (sample_value_i),
    .cfg_i       (cfg),
    .setup_i     (setup_busy),
    .jobq_full_i (jobq_full),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .done_i      (done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  ofe_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (jobq_full),
    .pop_i   (job_pop),
    .empty_o (jobq_empty),
    .data_o  (job_out)
  );

  ofe_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ofe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .jobq_empty_i (jobq_empty),
    .job_pop_o    (job_pop),
    .job_i        (job_out),
    .done_o       (done),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res)
  );

  assign out_channel_o       = res.ch;
  assign out_sample_o        = res.sample;
  assign position_in_frame_o = res.pos;
  assign frame_ok_o          = res.ok;
  assign last_of_frame_o     = res.last;

endmodule
